// ===== design/pfa_pkg.sv =====
package pfa_pkg;

  localparam int NUM_SLOTS_DEFAULT = 64;
  localparam int SIZE_BITS_DEFAULT = 16;

  localparam int AMOUNT_W = 16;
  localparam int SLOT_W = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  localparam logic [1:0] FIT_MODE_RESET = FIT_FIRST;
  localparam logic [6:0] BLOCK_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic opcode;
    logic [SLOT_W-1:0] slot_index;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic granted;
    logic [SLOT_W-1:0] chosen_slot;
  } rsp_t;

endpackage

// ===== design/partition_fit_allocator.sv =====
// Partition allocator over a table of free sizes held in one synchronous RAM. A load transaction
// writes one entry and does not raise req_stall. An allocate transaction scans entries
// 0 to L-1, where L is block_count saturated to NUM_SLOTS, at one RAM read per cycle. It then
// writes the reduced size back if an entry fits and posts the result. req_stall stays high from
// the taken allocation through the scan and ST_FINISH, so no new transaction is taken before
// the last one is through. With no partition in use it goes straight to ST_FINISH. A
// waiting result sits in an output register while the next transaction is taken, and only the
// posting of a new allocation result waits for that register to drain. Configuration
// registers: index 0 is fit_mode (first, best or worst fit) and index 1 is block_count.
module partition_fit_allocator #(
  parameter int NUM_SLOTS = pfa_pkg::NUM_SLOTS_DEFAULT,
  parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  pfa_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output pfa_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (SIZE_BITS > pfa_pkg::AMOUNT_W) ? SIZE_BITS : pfa_pkg::AMOUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  logic [1:0] fit_mode;
  logic [6:0] block_count;

  logic [SIZE_BITS-1:0] mem [NUM_SLOTS];
  logic [SIZE_BITS-1:0] rd_data;

  logic [pfa_pkg::AMOUNT_W-1:0] amt;
  logic [1:0] mode;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] issue_idx;
  logic issuing;
  logic data_valid;
  logic data_last;
  logic [IDX_W-1:0] data_idx;
  logic found;
  logic [IDX_W-1:0] pick;
  logic [SIZE_BITS-1:0] best;

  logic req_fire;
  logic load_fire;
  logic alloc_fire;
  logic slot_in_range;
  int lim;
  logic fits;
  logic take;
  logic finish_fire;
  logic mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [SIZE_BITS-1:0] mem_wd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_fire = req_valid && !req_stall;
  assign load_fire = req_fire && (req.opcode == pfa_pkg::OP_LOAD);
  assign alloc_fire = req_fire && (req.opcode == pfa_pkg::OP_ALLOC);
  assign slot_in_range = int'(req.slot_index) < NUM_SLOTS;
  assign lim = (int'(block_count) > NUM_SLOTS) ? NUM_SLOTS : int'(block_count);
  assign finish_fire = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  always_comb begin
    fits = CMP_W'(rd_data) >= CMP_W'(amt);
    take = 1'b0;
    if (data_valid && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (mode == pfa_pkg::FIT_BEST) begin
        take = rd_data < best;
      end else if (mode == pfa_pkg::FIT_WORST) begin
        take = rd_data > best;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = IDX_W'(req.slot_index);
    mem_wd = SIZE_BITS'(req.amount);
    if (load_fire && slot_in_range) begin
      mem_we = 1'b1;
    end else if (finish_fire && found) begin
      mem_we = 1'b1;
      mem_wa = pick;
      mem_wd = best - SIZE_BITS'(amt);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[issue_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= pfa_pkg::FIT_MODE_RESET;
      block_count <= pfa_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pfa_pkg::CFG_FIT_MODE) begin
        fit_mode <= cfg_data[1:0];
      end else if (cfg_index == pfa_pkg::CFG_BLOCK_COUNT) begin
        block_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      data_valid <= (state == ST_SCAN) && issuing;
    end
    data_idx <= issue_idx;
    data_last <= issue_idx == last_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issuing <= 1'b0;
      issue_idx <= '0;
      found <= 1'b0;
      rsp_valid <= 1'b0;
      rsp <= '0;
    end else begin
      if (finish_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (alloc_fire) begin
            amt <= req.amount;
            mode <= fit_mode;
            last_idx <= IDX_W'(lim - 1);
            issue_idx <= '0;
            found <= 1'b0;
            pick <= '0;
            issuing <= (lim != 0);
            state <= (lim != 0) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (issue_idx == last_idx) begin
              issuing <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (take) begin
            found <= 1'b1;
            pick <= data_idx;
            best <= rd_data;
          end
          if (data_valid && data_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_fire) begin
            rsp.granted <= found;
            rsp.chosen_slot <= found ? pfa_pkg::SLOT_W'(pick) : '0;
            issue_idx <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pfa_checker.sv =====
module pfa_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input pfa_pkg::req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input pfa_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled result changed or was dropped.");

  a_no_grant_zero_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> rsp.chosen_slot == '0)
    else $error("Result without grant carries a nonzero slot.");

  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.opcode == pfa_pkg::OP_ALLOC |=> req_stall)
    else $error("Block took a transaction right after an allocation.");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.opcode == pfa_pkg::OP_LOAD |=> !req_stall)
    else $error("Load transaction held the block for more than one cycle.");

  a_rsp_from_alloc: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("Result appeared without an allocation in progress.");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = pfa_pkg::NUM_SLOTS_DEFAULT;
  localparam int TARGET_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [pfa_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  class fit_tracker;
    logic [pfa_pkg::AMOUNT_W-1:0] free_size [SLOTS];
    bit loaded [SLOTS];
    logic [1:0] policy;
    int scan_limit;
    pfa_pkg::rsp_t pending_grants [$];
    int unsigned mismatches;
    int unsigned loads;
    int unsigned requests;
    int unsigned grants;

    function new();
      policy = pfa_pkg::FIT_MODE_RESET;
      scan_limit = (pfa_pkg::BLOCK_COUNT_RESET > SLOTS) ? SLOTS
                                                         : int'(pfa_pkg::BLOCK_COUNT_RESET);
      foreach (loaded[j]) loaded[j] = 1'b0;
    endfunction

    function void apply_register(logic [pfa_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [pfa_pkg::CFG_DATA_W-1:0] data);
      if (idx == pfa_pkg::CFG_FIT_MODE) begin
        policy = data[1:0];
      end else if (idx == pfa_pkg::CFG_BLOCK_COUNT) begin
        scan_limit = (data > SLOTS) ? SLOTS : int'(data);
      end
    endfunction

    function int first_unloaded();
      for (int j = 0; j < scan_limit; j++) begin
        if (!loaded[j]) return j;
      end
      return -1;
    endfunction

    function void note_request(pfa_pkg::req_t r);
      int pick;
      bit found;
      pfa_pkg::rsp_t g;
      if (r.opcode == pfa_pkg::OP_LOAD) begin
        free_size[r.slot_index] = r.amount;
        loaded[r.slot_index] = 1'b1;
        loads++;
        return;
      end
      pick = 0;
      found = 1'b0;
      for (int j = 0; j < scan_limit; j++) begin
        if (free_size[j] < r.amount) continue;
        if (!found) begin
          found = 1'b1;
          pick = j;
          if (policy != pfa_pkg::FIT_BEST && policy != pfa_pkg::FIT_WORST) break;
        end else if (policy == pfa_pkg::FIT_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (policy == pfa_pkg::FIT_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
      g = '0;
      if (found) begin
        free_size[pick] = free_size[pick] - r.amount;
        g.granted = 1'b1;
        g.chosen_slot = pick[pfa_pkg::SLOT_W-1:0];
        grants++;
      end
      pending_grants.push_back(g);
      requests++;
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
      end
    endfunction

    function void check_grant(pfa_pkg::rsp_t got);
      pfa_pkg::rsp_t want;
      if (pending_grants.size() == 0) begin
        flag("unexpected result transaction", 0, 1);
        return;
      end
      want = pending_grants.pop_front();
      if (want.granted != got.granted) flag("granted", want.granted, got.granted);
      if (want.chosen_slot != got.chosen_slot) begin
        flag("chosen_slot", want.chosen_slot, got.chosen_slot);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  pfa_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  pfa_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data;

  fit_tracker sb = new();
  bit gaps_on = 1'b1;
  int items = 0;
  int phases = 0;

  partition_fit_allocator DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_request(input logic op, input logic [pfa_pkg::SLOT_W-1:0] slot,
                              input logic [pfa_pkg::AMOUNT_W-1:0] amt);
    pfa_pkg::req_t r;
    bit s;
    r.opcode = op;
    r.slot_index = slot;
    r.amount = amt;
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do begin
      @(negedge clk);
      s = req_stall;
      @(posedge clk);
    end while (s);
    sb.note_request(r);
    items++;
  endtask

  task automatic program_register(input logic [pfa_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [pfa_pkg::CFG_DATA_W-1:0] data, input bit last);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    sb.apply_register(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [pfa_pkg::AMOUNT_W-1:0] random_size();
    case ($urandom_range(0, 2))
      0: return pfa_pkg::AMOUNT_W'($urandom);
      1: return pfa_pkg::AMOUNT_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0040;
          1: return 16'h0100;
          2: return 16'h1000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  initial begin : grant_monitor
    bit v;
    bit s;
    pfa_pkg::rsp_t d;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      v = rsp_valid;
      s = rsp_stall;
      d = rsp;
      @(posedge clk);
      if (v && !s) sb.check_grant(d);
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 16);
    end
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int scan;
    int sel;
    int hole;
    int phase_len;
    logic [pfa_pkg::AMOUNT_W-1:0] amt;
    logic [pfa_pkg::CFG_DATA_W-1:0] mode_data;
    logic [pfa_pkg::CFG_DATA_W-1:0] count_data;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    program_register(CFG_SPARE, 7'h7F, 1'b0);
    program_register(pfa_pkg::CFG_FIT_MODE, 7'(pfa_pkg::FIT_FIRST), 1'b0);
    program_register(pfa_pkg::CFG_BLOCK_COUNT, 7'd4, 1'b1);
    send_request(pfa_pkg::OP_LOAD, 6'd0, 16'hFFFF);
    send_request(pfa_pkg::OP_LOAD, 6'd1, 16'h0000);
    send_request(pfa_pkg::OP_LOAD, 6'd2, 16'h8000);
    send_request(pfa_pkg::OP_LOAD, 6'd3, 16'h8000);
    send_request(pfa_pkg::OP_LOAD, 6'h3F, 16'h7FFF);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0000);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'hFFFF);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h8000);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h8001);
    send_request(pfa_pkg::OP_ALLOC, 6'h3F, 16'h0001);
    req_valid <= 1'b0;
    settle();

    program_register(pfa_pkg::CFG_FIT_MODE, 7'(pfa_pkg::FIT_BEST), 1'b1);
    send_request(pfa_pkg::OP_LOAD, 6'd0, 16'h0010);
    send_request(pfa_pkg::OP_LOAD, 6'd1, 16'h0010);
    send_request(pfa_pkg::OP_LOAD, 6'd2, 16'h0100);
    send_request(pfa_pkg::OP_LOAD, 6'd3, 16'h0008);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0008);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0009);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0101);
    req_valid <= 1'b0;
    settle();

    program_register(pfa_pkg::CFG_FIT_MODE, 7'(pfa_pkg::FIT_WORST), 1'b1);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0001);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0000);
    req_valid <= 1'b0;
    settle();

    program_register(pfa_pkg::CFG_FIT_MODE, 7'h7F, 1'b0);
    program_register(pfa_pkg::CFG_BLOCK_COUNT, 7'd0, 1'b1);
    send_request(pfa_pkg::OP_ALLOC, 6'd0, 16'h0000);
    req_valid <= 1'b0;
    settle();

    while (items < TARGET_ITEMS) begin
      gaps_on = !(items >= 450 && items < 700);
      if ($urandom_range(0, 3) == 0) mode_data = 7'($urandom_range(0, 127));
      else mode_data = 7'($urandom_range(0, 3));
      sel = $urandom_range(0, 19);
      if (sel < 2) count_data = 7'd0;
      else if (sel < 4) count_data = 7'd1;
      else if (sel < 7) count_data = 7'($urandom_range(64, 127));
      else count_data = 7'($urandom_range(2, 16));
      program_register(pfa_pkg::CFG_FIT_MODE, mode_data, 1'b0);
      program_register(pfa_pkg::CFG_BLOCK_COUNT, count_data, 1'b1);
      scan = sb.scan_limit;
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        sel = $urandom_range(0, 99);
        hole = sb.first_unloaded();
        if (sel < 35) begin
          if (scan > 0 && sel < 28) begin
            send_request(pfa_pkg::OP_LOAD, pfa_pkg::SLOT_W'($urandom_range(0, scan - 1)),
                         random_size());
          end else begin
            send_request(pfa_pkg::OP_LOAD, pfa_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)),
                         random_size());
          end
        end else if (hole >= 0) begin
          send_request(pfa_pkg::OP_LOAD, pfa_pkg::SLOT_W'(hole), random_size());
        end else begin
          case ($urandom_range(0, 9))
            0: amt = '0;
            1: amt = pfa_pkg::AMOUNT_W'($urandom);
            2, 3, 4: amt = (scan > 0) ? sb.free_size[$urandom_range(0, scan - 1)] : '0;
            default: amt = pfa_pkg::AMOUNT_W'($urandom_range(0, 64));
          endcase
          send_request(pfa_pkg::OP_ALLOC, pfa_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)),
                       amt);
        end
      end
      req_valid <= 1'b0;
      settle();
      phases++;
    end

    $display("Covered %0d partition loads and %0d allocation requests across %0d settings.",
             sb.loads, sb.requests, phases + 4);
    $display("Requests granted: %0d, refused: %0d, mismatches: %0d.",
             sb.grants, sb.requests - sb.grants, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
